// ===== sv/i2c_bit_level_master_assert.svh =====
// Assertion macros shared by the I2C bit-level master RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef I2C_BIT_LEVEL_MASTER_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define I2CBL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2CBL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2cbl_pkg.sv =====
// Package for the I2C bit-level master: command codes, sizes, result type.
// No dependencies; used by every module of the block.
package i2cbl_pkg;

    localparam int TICK_COUNTER_WIDTH_DEF = 16;
    localparam int BITS_PER_BYTE          = 8;
    localparam int QUANTUM_W              = 16;
    localparam int SLOT_W                 = 6;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd64;
    localparam logic [SLOT_W-1:0]    SLOT_LAST     = SLOT_W'(4 * BITS_PER_BYTE);

    typedef enum logic [2:0] {
        MODE_START = 3'd0,
        MODE_STOP  = 3'd1,
        MODE_ACK   = 3'd2,
        MODE_NACK  = 3'd3,
        MODE_WACK  = 3'd4,
        MODE_SEND  = 3'd5,
        MODE_READ  = 3'd6
    } mode_t;

    typedef struct packed {
        logic                     scl_level;
        logic                     sda_level;
        logic                     sda_drive;
        logic                     ready_res;
        logic                     done_res;
        logic [BITS_PER_BYTE-1:0] rx_byte;
        logic                     ack_seen;
        logic                     start_ok;
    } result_t;

endpackage

// ===== sv/i2cbl_seq.sv =====
// Command sequencer of the I2C bit-level master: tick counting, slot actions, line state.
// Depends on i2cbl_pkg and i2c_bit_level_master_assert.svh.
`include "i2c_bit_level_master_assert.svh"

module i2cbl_seq #(
    parameter int TICK_COUNTER_WIDTH = i2cbl_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [i2cbl_pkg::QUANTUM_W-1:0]   cfg_wdata,
    input  logic                              accept,
    input  logic                              cmd_valid,
    input  logic [2:0]                        mode,
    input  logic [i2cbl_pkg::BITS_PER_BYTE-1:0] tx_byte,
    input  logic                              sda_in,
    output i2cbl_pkg::result_t                res
);

    localparam int CW = ((TICK_COUNTER_WIDTH > i2cbl_pkg::QUANTUM_W) ?
                         TICK_COUNTER_WIDTH : i2cbl_pkg::QUANTUM_W) + 1;
    localparam logic [CW-1:0] CAP = {{(CW-1){1'b0}}, 1'b1} << TICK_COUNTER_WIDTH;
    localparam int BW = i2cbl_pkg::BITS_PER_BYTE;

    logic [i2cbl_pkg::QUANTUM_W-1:0] quantum_reg;
    logic [TICK_COUNTER_WIDTH-1:0]   tick_reg, tick_next;
    logic [i2cbl_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [BW-1:0]                   shift_reg, shift_next;
    logic [BW-1:0]                   rx_reg, rx_next;
    i2cbl_pkg::mode_t                cmd_reg, cmd_next;
    logic                            busy_reg, busy_next;
    logic                            scl_reg, scl_next;
    logic                            sda_reg, sda_next;
    logic                            oe_reg, oe_next;
    logic                            ack_reg, ack_next;
    logic                            start_reg, start_next;

    logic [CW-1:0]                   tick_plus;
    logic                            run;
    logic                            done;
    logic [i2cbl_pkg::SLOT_W-1:0]    s;
    logic [1:0]                      ph;
    i2cbl_pkg::mode_t                cmd_sel;

    always_comb begin
        tick_next  = tick_reg;
        slot_next  = slot_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        cmd_next   = cmd_reg;
        busy_next  = busy_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        oe_next    = oe_reg;
        ack_next   = ack_reg;
        start_next = start_reg;
        run        = 1'b0;
        done       = 1'b0;
        s          = slot_reg;
        cmd_sel    = cmd_reg;
        tick_plus  = CW'(tick_reg) + CW'(1);

        if (busy_reg) begin
            // quantum ends when the count reaches the quantum or the counter span
            if ((tick_plus >= CW'(quantum_reg)) || (tick_plus == CAP)) begin
                tick_next = '0;
                slot_next = slot_reg + 1'b1;
                s         = slot_next;
                run       = 1'b1;
            end else begin
                tick_next = tick_plus[TICK_COUNTER_WIDTH-1:0];
            end
        end else if (cmd_valid && (mode <= i2cbl_pkg::MODE_READ)) begin
            cmd_sel   = i2cbl_pkg::mode_t'(mode);
            cmd_next  = cmd_sel;
            busy_next = 1'b1;
            tick_next = '0;
            slot_next = '0;
            s         = '0;
            run       = 1'b1;
            if (cmd_sel == i2cbl_pkg::MODE_SEND) begin
                shift_next = tx_byte;
            end
        end

        ph = s[1:0];

        if (run) begin
            case (cmd_sel)
                i2cbl_pkg::MODE_START: begin
                    if (s == 6'd0) begin
                        sda_next = 1'b1;
                        oe_next  = 1'b1;
                        scl_next = 1'b1;
                    end else if (s == 6'd1) begin
                        // bus must be free before pulling SDA low
                        if (!sda_in) begin
                            start_next = 1'b0;
                            done       = 1'b1;
                        end else begin
                            sda_next = 1'b0;
                        end
                    end else if (s == 6'd2) begin
                        if (sda_in) begin
                            start_next = 1'b0;
                            done       = 1'b1;
                        end
                    end else begin
                        start_next = 1'b1;
                        done       = 1'b1;
                    end
                end
                i2cbl_pkg::MODE_STOP: begin
                    if (s == 6'd0) scl_next = 1'b0;
                    else if (s == 6'd1) begin
                        sda_next = 1'b0;
                        oe_next  = 1'b1;
                    end else if (s == 6'd2) scl_next = 1'b1;
                    else if (s == 6'd3) sda_next = 1'b1;
                    else done = 1'b1;
                end
                i2cbl_pkg::MODE_ACK: begin
                    if (s == 6'd0) scl_next = 1'b0;
                    else if (s == 6'd1) begin
                        sda_next = 1'b0;
                        oe_next  = 1'b1;
                    end else if (s == 6'd2) scl_next = 1'b1;
                    else if (s == 6'd4) scl_next = 1'b0;
                    else if (s >= 6'd5) done = 1'b1;
                end
                i2cbl_pkg::MODE_NACK: begin
                    if (s == 6'd0) scl_next = 1'b0;
                    else if (s == 6'd1) begin
                        sda_next = 1'b1;
                        oe_next  = 1'b1;
                    end else if (s == 6'd2) scl_next = 1'b1;
                    else if (s == 6'd3) scl_next = 1'b0;
                    else done = 1'b1;
                end
                i2cbl_pkg::MODE_WACK: begin
                    if (s == 6'd0) scl_next = 1'b0;
                    else if (s == 6'd2) begin
                        scl_next = 1'b1;
                        oe_next  = 1'b0;
                    end else if (s >= 6'd4) begin
                        ack_next = ~sda_in;
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                end
                i2cbl_pkg::MODE_SEND: begin
                    if (s >= i2cbl_pkg::SLOT_LAST) begin
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end else if (ph == 2'd0) begin
                        scl_next = 1'b0;
                        if (s == 6'd0) oe_next = 1'b1;
                    end else if (ph == 2'd1) begin
                        sda_next   = shift_next[BW-1];
                        shift_next = {shift_next[BW-2:0], 1'b0};
                    end else if (ph == 2'd2) begin
                        scl_next = 1'b1;
                    end
                end
                i2cbl_pkg::MODE_READ: begin
                    // sample at the end of each SCL-high phase
                    if ((s != 6'd0) && (ph == 2'd0)) begin
                        shift_next = {shift_next[BW-2:0], sda_in};
                    end
                    if (s >= i2cbl_pkg::SLOT_LAST) begin
                        scl_next = 1'b0;
                        rx_next  = shift_next;
                        done     = 1'b1;
                    end else begin
                        if (s == 6'd0) begin
                            sda_next   = 1'b1;
                            oe_next    = 1'b1;
                            shift_next = '0;
                        end
                        if (ph == 2'd0) scl_next = 1'b0;
                        else if (ph == 2'd2) begin
                            scl_next = 1'b1;
                            oe_next  = 1'b0;
                        end
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
        end

        if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= i2cbl_pkg::QUANTUM_RESET;
        end else if (cfg_we) begin
            quantum_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= '0;
            slot_reg  <= '0;
            shift_reg <= '0;
            rx_reg    <= '0;
            cmd_reg   <= i2cbl_pkg::MODE_START;
            busy_reg  <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            oe_reg    <= 1'b1;
            ack_reg   <= 1'b0;
            start_reg <= 1'b0;
        end else if (accept) begin
            tick_reg  <= tick_next;
            slot_reg  <= slot_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
            cmd_reg   <= cmd_next;
            busy_reg  <= busy_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            oe_reg    <= oe_next;
            ack_reg   <= ack_next;
            start_reg <= start_next;
        end
    end

    always_comb begin
        res.scl_level = scl_next;
        res.sda_level = sda_next;
        res.sda_drive = oe_next;
        res.ready_res = ~busy_next;
        res.done_res  = done;
        res.rx_byte   = rx_next;
        res.ack_seen  = ack_next;
        res.start_ok  = start_next;
    end

    `I2CBL_ASSERT_NEXT(a_done_goes_idle, aclk, aresetn, accept && done, !busy_reg,
        "sequencer still busy after a completed command")
    `I2CBL_ASSERT_NOW(a_slot_in_range, aclk, aresetn, busy_reg,
        slot_reg < i2cbl_pkg::SLOT_LAST, "slot index ran past the last slot")
    `I2CBL_ASSERT_NEXT(a_idle_lines_hold, aclk, aresetn, accept && !busy_reg && !cmd_valid,
        $stable(scl_reg) && $stable(sda_reg) && $stable(oe_reg),
        "bus lines moved on an idle tick")

endmodule

// ===== sv/i2cbl_outq.sv =====
// Two-entry result buffer of the I2C bit-level master between sequencer and output stream.
// Depends on i2cbl_pkg and i2c_bit_level_master_assert.svh.
`include "i2c_bit_level_master_assert.svh"

module i2cbl_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  i2cbl_pkg::result_t din,
    output logic               pop_valid,
    input  logic               pop_ready,
    output i2cbl_pkg::result_t dout
);

    i2cbl_pkg::result_t head_reg, tail_reg;
    logic [1:0]         count_reg;
    logic               push, pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign dout       = head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_reg <= din;
                end else begin
                    head_reg <= tail_reg;
                    tail_reg <= din;
                end
            end
            2'b10: begin
                if (count_reg == 2'd0) head_reg <= din;
                else tail_reg <= din;
            end
            2'b01: begin
                head_reg <= tail_reg;
            end
            default: begin
                head_reg <= head_reg;
            end
        endcase
    end

    `I2CBL_ASSERT_NEXT(a_drain_empties, aclk, aresetn, pop && !push && (count_reg == 2'd1),
        !pop_valid, "buffer still shows a result after draining its last one")
    `I2CBL_ASSERT_NEXT(a_first_push_heads, aclk, aresetn,
        push && !pop && (count_reg == 2'd0),
        pop_valid && (dout == $past(din)), "request into an empty buffer not at its head")

endmodule

// ===== sv/i2c_bit_level_master.sv =====
// I2C bit-level master: each stream request is one clock tick, possibly carrying a bus command;
// each tick yields one result with the SCL/SDA line state. Depends on i2cbl_pkg, i2cbl_seq, i2cbl_outq.
//
// Usage:
//   s_axis: one request per bus tick. tuser carries cmd_valid and mode, tdata carries
//   tx_byte and the sampled SDA level. A command is taken only while the sequencer is idle;
//   otherwise it is dropped, as is mode seven.
//   m_axis: one result per request: line levels, ready, done pulse, read byte, ACK and
//   START status, all in tdata.
//   cfg_we/cfg_wdata: write quantum_ticks (ticks per quarter SCL period); write it only
//   while idle. Zero acts as one.
// Timing: one request per cycle while m_axis_tready is high. The sequencer step is a single
//   registered pass, and its result is registered into the result buffer that feeds m_axis.
//   A two-entry result buffer sits in front of m_axis, so s_axis_tready stays high while
//   one result waits; it drops only when two results are waiting.
// Reset (aresetn low, synchronous): SCL and SDA high and driven, sequencer idle,
//   quantum_ticks 64, result buffer empty.
// Stall: while m_axis_tready is low the buffer fills and then s_axis_tready falls;
//   the bus sequence holds, since it only advances on accepted requests.
module i2c_bit_level_master #(
    parameter int TICK_COUNTER_WIDTH = i2cbl_pkg::TICK_COUNTER_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: quantum_ticks
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] sda_in, [15:9] zero
    input  logic [3:0]  s_axis_tuser,   // [0] cmd_valid, [3:1] mode
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] scl_level, [1] sda_level, [2] sda_drive,
                                        // [3] ready_res, [4] done_res, [12:5] rx_byte,
                                        // [13] ack_seen, [14] start_ok, [15] zero
);

    i2cbl_pkg::result_t step_res;
    i2cbl_pkg::result_t out_res;
    logic               accept;

    // the sequencer advances only on a request that the buffer takes
    assign accept = s_axis_tvalid && s_axis_tready;

    i2cbl_seq #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .cmd_valid (s_axis_tuser[0]),
        .mode      (s_axis_tuser[3:1]),
        .tx_byte   (s_axis_tdata[7:0]),
        .sda_in    (s_axis_tdata[8]),
        .res       (step_res)
    );

    i2cbl_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .din        (step_res),
        .pop_valid  (m_axis_tvalid),
        .pop_ready  (m_axis_tready),
        .dout       (out_res)
    );

    // pack result fields, highest bit listed first
    assign m_axis_tdata = {1'b0,
                           out_res.start_ok,
                           out_res.ack_seen,
                           out_res.rx_byte,
                           out_res.done_res,
                           out_res.ready_res,
                           out_res.sda_drive,
                           out_res.sda_level,
                           out_res.scl_level};

endmodule
